// ===== hdl/rwct_pkg.sv =====
// Shared types and constants for the raycast wall column texturer.
package rwct_pkg;

    localparam int SCREEN_HEIGHT = 480;
    localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;
    localparam int TEX_W_BITS    = 6;
    localparam int TEX_H_BITS    = 6;
    localparam int TEX_SEL_BITS  = 2;
    localparam int ADDR_W        = TEX_SEL_BITS + TEX_H_BITS + TEX_W_BITS;
    localparam int STORE_DEPTH   = 1 << ADDR_W;
    localparam int DIV_W         = 40;
    localparam int LH_W          = 25;
    localparam int CFG_IDX_W     = 1;

    localparam logic [DIV_W-1:0] LH_SAT   = DIV_W'(SCREEN_HEIGHT * 65536);
    localparam logic [DIV_W-1:0] STEP_NUM = DIV_W'((1 << TEX_H_BITS) * 65536);
    localparam logic [8:0]       HALF_H9  = 9'(HALF_HEIGHT);
    localparam logic [8:0]       LAST_ROW = 9'(SCREEN_HEIGHT - 1);

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_SETUP = 2'd1;
    localparam logic [1:0] MODE_PIXEL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ABOVE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BELOW = 1'd1;

    typedef enum logic [1:0] {
        K_WRITE,
        K_SETUP,
        K_PIXEL
    } kind_t;

    typedef enum logic [1:0] {
        SRC_ABOVE,
        SRC_TEXEL,
        SRC_BELOW
    } src_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX,
        ST_DIST_WAIT,
        ST_LH_START,
        ST_LH_WAIT,
        ST_STEP_START,
        ST_STEP_WAIT,
        ST_POS
    } state_t;

    typedef struct packed {
        kind_t                   kind;
        logic [ADDR_W-1:0]       tex_addr;
        logic [23:0]             texel;
        logic [9:0]              column;
        logic [8:0]              row;
        logic                    num_neg;
        logic [22:0]             num_mag;
        logic                    dir_neg;
        logic                    dir_zero;
        logic [17:0]             dir_mag;
        logic [15:0]             opos_frac;
        logic signed [17:0]      odir;
        logic [TEX_SEL_BITS-1:0] tsel;
        logic                    mirror;
    } item_t;

endpackage

// ===== hdl/rwct_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module rwct_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rwct_pkg::DIV_W-1:0]     dividend,
    input  logic [rwct_pkg::DIV_W-1:0]     divisor,
    output logic                           done,
    output logic [rwct_pkg::DIV_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(rwct_pkg::DIV_W + 1);

    logic                       busy_reg, busy_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [rwct_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [rwct_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [rwct_pkg::DIV_W-1:0] dsr_reg, dsr_next;
    logic                       done_reg, done_next;
    logic [rwct_pkg::DIV_W:0]   trial;
    logic                       fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[rwct_pkg::DIV_W-1]};
        fits      = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(rwct_pkg::DIV_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rwct_pkg::DIV_W'(trial - {1'b0, dsr_reg})
                            : trial[rwct_pkg::DIV_W-1:0];
            quo_next = {quo_reg[rwct_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/rwct_front.sv =====
// Front end: accepts beats, decodes the mode, picks side operands, queues items.
module rwct_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  logic [13:0]         tex_addr,
    input  logic [23:0]         texel,
    input  logic                side,
    input  logic [5:0]          cell_x,
    input  logic [5:0]          cell_y,
    input  logic [21:0]         pos_x,
    input  logic [21:0]         pos_y,
    input  logic signed [17:0]  dir_x,
    input  logic signed [17:0]  dir_y,
    input  logic [9:0]          column,
    input  logic [8:0]          row,
    output logic                deq_valid,
    input  logic                deq_ready,
    output rwct_pkg::item_t     deq_item
);

    rwct_pkg::item_t      q_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    rwct_pkg::item_t      item;
    logic                 keep;
    logic                 push, pop;
    logic signed [24:0]   num;
    logic signed [17:0]   dir;
    logic [5:0]           cell_sel;
    logic [21:0]          pos;

    always_comb
    begin
        item       = '0;
        keep       = 1'b1;
        cell_sel   = side ? cell_y : cell_x;
        pos        = side ? pos_y : pos_x;
        dir        = side ? dir_y : dir_x;
        num        = $signed({3'b0, cell_sel, 16'b0}) - $signed({3'b0, pos})
                     + (dir[17] ? 25'sd65536 : 25'sd0);
        item.tex_addr  = tex_addr;
        item.texel     = texel;
        item.column    = column;
        item.row       = row;
        item.num_neg   = num[24];
        item.num_mag   = 23'(num[24] ? -num : num);
        item.dir_neg   = dir[17];
        item.dir_mag   = dir[17] ? 18'(-dir) : 18'(dir);
        item.dir_zero  = dir == '0;
        item.opos_frac = side ? pos_x[15:0] : pos_y[15:0];
        item.odir      = side ? dir_x : dir_y;
        // N/S on horizontal faces, W/E on vertical ones
        item.tsel      = side ? {1'b0, dir_y[17]} : {1'b1, dir_x[17]};
        item.mirror    = side ? dir_y[17] : (!dir_x[17] && dir_x != '0);
        unique case (mode)
            rwct_pkg::MODE_WRITE: item.kind = rwct_pkg::K_WRITE;
            rwct_pkg::MODE_SETUP: item.kind = rwct_pkg::K_SETUP;
            rwct_pkg::MODE_PIXEL: item.kind = rwct_pkg::K_PIXEL;
            default:
            begin
                item.kind = rwct_pkg::K_WRITE;
                keep      = 1'b0;
            end
        endcase
    end

    assign in_ready  = count_reg != 2'd2;
    assign deq_valid = count_reg != 2'd0;
    assign deq_item  = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready && keep;
    assign pop       = deq_valid && deq_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= item;
    end

endmodule

// ===== hdl/rwct_back.sv =====
// Back end: texture store, column setup sequencer and pixel output register.
module rwct_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                deq_valid,
    output logic                deq_ready,
    input  rwct_pkg::item_t     deq_item,
    input  logic [23:0]         above_color,
    input  logic [23:0]         below_color,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [9:0]          out_column,
    output logic [8:0]          out_row,
    output logic [23:0]         color
);

    localparam int AW = rwct_pkg::ADDR_W;
    localparam int DW = rwct_pkg::DIV_W;

    logic [23:0] mem [rwct_pkg::STORE_DEPTH];

    rwct_pkg::state_t state_reg, state_next;
    logic [9:0]   col_reg, col_next;
    logic [1:0]   tsel_reg, tsel_next;
    logic [5:0]   tcol_reg, tcol_next;
    logic [8:0]   ss_reg, ss_next;
    logic [8:0]   se_reg, se_next;
    logic [31:0]  pos_reg, pos_next;
    logic [31:0]  step_reg, step_next;

    logic                mirror_reg, mirror_next;
    logic                neg_reg, neg_next;
    logic [15:0]         opos_reg, opos_next;
    logic signed [17:0]  odir_reg, odir_next;
    logic [DW-1:0]       dist_reg, dist_next;
    logic [31:0]         prod_reg, prod_next;
    logic [rwct_pkg::LH_W-1:0] lh_reg, lh_next;

    rwct_pkg::src_t src_reg, src_next;
    logic [8:0]     prow_reg, prow_next;
    logic           ov_reg, ov_next;
    logic [9:0]     ocol_reg, ocol_next;
    logic [8:0]     orow_reg, orow_next;
    logic [23:0]    ocolor_reg, ocolor_next;

    logic           wr_en, rd_en;
    logic [AW-1:0]  rd_addr;
    logic [23:0]    rd_data_reg;

    logic           div_start, div_done;
    logic [DW-1:0]  div_a, div_b, div_q;

    logic           pop;
    logic [23:0]    half;
    logic           big;
    logic [15:0]    wall_frac;
    logic [5:0]     tcol_raw;
    logic [31:0]    k32;
    logic [31:0]    odir32;

    rwct_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign deq_ready = state_reg == rwct_pkg::ST_IDLE;
    assign pop       = deq_valid && deq_ready;

    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        tsel_next   = tsel_reg;
        tcol_next   = tcol_reg;
        ss_next     = ss_reg;
        se_next     = se_reg;
        pos_next    = pos_reg;
        step_next   = step_reg;
        mirror_next = mirror_reg;
        neg_next    = neg_reg;
        opos_next   = opos_reg;
        odir_next   = odir_reg;
        dist_next   = dist_reg;
        prod_next   = prod_reg;
        lh_next     = lh_reg;
        src_next    = src_reg;
        prow_next   = prow_reg;
        ov_next     = ov_reg && !out_ready;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        ocolor_next = ocolor_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = {tsel_reg, pos_reg[16 +: rwct_pkg::TEX_H_BITS], tcol_reg};
        div_start   = 1'b0;
        div_a       = '0;
        div_b       = '0;
        half        = lh_reg[rwct_pkg::LH_W-1:1];
        big         = half >= 24'(rwct_pkg::HALF_HEIGHT);
        wall_frac   = opos_reg + prod_reg[31:16];
        tcol_raw    = wall_frac[15 -: rwct_pkg::TEX_W_BITS];
        k32         = big ? 32'(half - 24'(rwct_pkg::HALF_HEIGHT)) : 32'd0;
        odir32      = 32'(odir_reg);

        unique case (state_reg)
            rwct_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    unique case (deq_item.kind)
                        rwct_pkg::K_WRITE: wr_en = 1'b1;
                        rwct_pkg::K_PIXEL:
                        begin
                            prow_next  = deq_item.row;
                            state_next = rwct_pkg::ST_PIX;
                            if (deq_item.row < ss_reg)
                                src_next = rwct_pkg::SRC_ABOVE;
                            else if (deq_item.row <= se_reg)
                            begin
                                src_next = rwct_pkg::SRC_TEXEL;
                                rd_en    = 1'b1;
                                pos_next = pos_reg + step_reg;
                            end
                            else
                                src_next = rwct_pkg::SRC_BELOW;
                        end
                        default:
                        begin
                            col_next    = deq_item.column;
                            tsel_next   = deq_item.tsel;
                            mirror_next = deq_item.mirror;
                            opos_next   = deq_item.opos_frac;
                            odir_next   = deq_item.odir;
                            neg_next    = deq_item.num_neg ^ deq_item.dir_neg;
                            if (deq_item.dir_zero)
                            begin
                                dist_next  = '0;
                                state_next = rwct_pkg::ST_LH_START;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                div_a      = DW'({deq_item.num_mag, 16'b0});
                                div_b      = DW'(deq_item.dir_mag);
                                state_next = rwct_pkg::ST_DIST_WAIT;
                            end
                        end
                    endcase
                end
            end
            rwct_pkg::ST_PIX:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next   = 1'b1;
                    ocol_next = col_reg;
                    orow_next = prow_reg;
                    case (src_reg)
                        rwct_pkg::SRC_ABOVE: ocolor_next = above_color;
                        rwct_pkg::SRC_TEXEL: ocolor_next = rd_data_reg;
                        default:             ocolor_next = below_color;
                    endcase
                    state_next = rwct_pkg::ST_IDLE;
                end
            end
            rwct_pkg::ST_DIST_WAIT:
            begin
                if (div_done)
                begin
                    dist_next  = neg_reg ? DW'(-div_q) : div_q;
                    state_next = rwct_pkg::ST_LH_START;
                end
            end
            rwct_pkg::ST_LH_START:
            begin
                // only the low 32 bits of dist * dir reach the wall fraction
                prod_next = dist_reg[31:0] * odir32;
                if (!dist_reg[DW-1] && dist_reg != '0)
                begin
                    div_start  = 1'b1;
                    div_a      = rwct_pkg::LH_SAT;
                    div_b      = dist_reg;
                    state_next = rwct_pkg::ST_LH_WAIT;
                end
                else
                begin
                    lh_next    = rwct_pkg::LH_W'(rwct_pkg::LH_SAT);
                    state_next = rwct_pkg::ST_STEP_START;
                end
            end
            rwct_pkg::ST_LH_WAIT:
            begin
                if (div_done)
                begin
                    lh_next    = div_q[rwct_pkg::LH_W-1:0];
                    state_next = rwct_pkg::ST_STEP_START;
                end
            end
            rwct_pkg::ST_STEP_START:
            begin
                ss_next   = big ? 9'd0 : rwct_pkg::HALF_H9 - half[8:0];
                se_next   = big ? rwct_pkg::LAST_ROW : rwct_pkg::HALF_H9 + half[8:0];
                tcol_next = mirror_reg ? ~tcol_raw : tcol_raw;
                if (lh_reg == '0)
                begin
                    step_next  = '1;
                    state_next = rwct_pkg::ST_POS;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_a      = rwct_pkg::STEP_NUM;
                    div_b      = DW'(lh_reg);
                    state_next = rwct_pkg::ST_STEP_WAIT;
                end
            end
            rwct_pkg::ST_STEP_WAIT:
            begin
                if (div_done)
                begin
                    step_next  = div_q[31:0];
                    state_next = rwct_pkg::ST_POS;
                end
            end
            default:
            begin
                pos_next   = k32 * step_reg;
                state_next = rwct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rwct_pkg::ST_IDLE;
            col_reg   <= '0;
            tsel_reg  <= '0;
            tcol_reg  <= '0;
            ss_reg    <= '0;
            se_reg    <= '0;
            pos_reg   <= '0;
            step_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            tsel_reg  <= tsel_next;
            tcol_reg  <= tcol_next;
            ss_reg    <= ss_next;
            se_reg    <= se_next;
            pos_reg   <= pos_next;
            step_reg  <= step_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mirror_reg <= mirror_next;
        neg_reg    <= neg_next;
        opos_reg   <= opos_next;
        odir_reg   <= odir_next;
        dist_reg   <= dist_next;
        prod_reg   <= prod_next;
        lh_reg     <= lh_next;
        src_reg    <= src_next;
        prow_reg   <= prow_next;
        ocol_reg   <= ocol_next;
        orow_reg   <= orow_next;
        ocolor_reg <= ocolor_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[deq_item.tex_addr] <= deq_item.texel;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign out_valid  = ov_reg;
    assign out_column = ocol_reg;
    assign out_row    = orow_reg;
    assign color      = ocolor_reg;

endmodule

// ===== hdl/raycast_wall_column_texturer_unit.sv =====
// Top level of the raycast wall column texturer: config registers, front end, back end.
//
// A pixel row request leaves the two-entry queue and issues the texture
// store read in the idle state, then loads the output register from the
// registered read in the pixel state. A texel write completes as it leaves
// the queue. A column setup runs three serial divisions (distance, line
// height, row step) on one shared divider that retires one quotient bit per
// cycle; a division is skipped for a zero direction (distance), a distance
// of zero or less (line height) or a zero line height (row step). Every
// beat is registered in the queue first. The front end keeps accepting into
// the queue, until it is full, while the back end works; a finished pixel
// waits in the output register, and the next pixel stalls behind it until
// it is taken.
// The texture store has no reset; a texel must be written before it is read.
module raycast_wall_column_texturer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic [13:0]                         tex_addr,
    input  logic [23:0]                         texel,
    input  logic                                side,
    input  logic [5:0]                          cell_x,
    input  logic [5:0]                          cell_y,
    input  logic [21:0]                         pos_x,
    input  logic [21:0]                         pos_y,
    input  logic signed [17:0]                  dir_x,
    input  logic signed [17:0]                  dir_y,
    input  logic [9:0]                          column,
    input  logic [8:0]                          row,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [9:0]                          out_column,
    output logic [8:0]                          out_row,
    output logic [23:0]                         color,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rwct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [23:0]                         cfg_data
);

    logic [23:0]     above_reg, above_next;
    logic [23:0]     below_reg, below_next;
    logic            deq_valid, deq_ready;
    rwct_pkg::item_t deq_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        above_next = above_reg;
        below_next = below_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                rwct_pkg::CFG_ABOVE: above_next = cfg_data;
                default:             below_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg <= '0;
            below_reg <= '0;
        end
        else
        begin
            above_reg <= above_next;
            below_reg <= below_next;
        end
    end

    rwct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .tex_addr  (tex_addr),
        .texel     (texel),
        .side      (side),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .column    (column),
        .row       (row),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_item  (deq_item)
    );

    rwct_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .deq_valid   (deq_valid),
        .deq_ready   (deq_ready),
        .deq_item    (deq_item),
        .above_color (above_reg),
        .below_color (below_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_column  (out_column),
        .out_row     (out_row),
        .color       (color)
    );

endmodule
